/* rtl/core/segment_pair_intersection_core_macros.svh */
// assertion macros for the segment pair intersection core checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SEGMENT_PAIR_INTERSECTION_CORE_MACROS_SVH
`define SEGMENT_PAIR_INTERSECTION_CORE_MACROS_SVH

// same-cycle implication
`define SPI_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment pair intersection check failed");

// next-cycle implication
`define SPI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment pair intersection check failed");

`endif

/* rtl/core/spi_pkg.sv */
// shared types and codes of the segment pair intersection core
// no dependencies
`default_nettype none

package spi_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_NONE    = 2'd0;
    localparam kind_t KIND_CROSS   = 2'd1;
    localparam kind_t KIND_OVERLAP = 2'd2;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_PAR_TOL = 2'd0;
    localparam reg_idx_t REG_COL_TOL = 2'd1;
    localparam reg_idx_t REG_OVL_TOL = 2'd2;

    localparam int TOL_W     = 48;
    localparam int OVL_TOL_W = 16;

endpackage

`default_nettype wire

/* rtl/core/segment_pair_intersection_core.sv */
// segment pair intersection core: pipelined 2d segment crossing and overlap test
// depends on spi_pkg
`default_nettype none

// Takes one segment pair per clock on start and never raises busy. Each
// word comes back on done in order, for one cycle only, with no way to
// hold it off. The depth is set by the quotient unit, which retires one
// quotient bit per pipeline stage (PARAM_FRAC_BITS + 2 stages), plus four
// stages in front (differences, products, sums, classification) and four
// behind (clipping, point product, rounding, saturation and output).
// The tolerance registers sit on the APB port at byte offsets 0, 8 and 16;
// write them only while no word is in flight.
module segment_pair_intersection_core #(
    parameter int COORD_WIDTH     = 24,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [spi_pkg::CFG_ADDR_W-1:0]       paddr,
    input  wire logic [spi_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic      [spi_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                      pready,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [COORD_WIDTH-1:0]        a_x,
    input  wire logic signed [COORD_WIDTH-1:0]        a_y,
    input  wire logic signed [COORD_WIDTH-1:0]        b_x,
    input  wire logic signed [COORD_WIDTH-1:0]        b_y,
    input  wire logic signed [COORD_WIDTH-1:0]        c_x,
    input  wire logic signed [COORD_WIDTH-1:0]        c_y,
    input  wire logic signed [COORD_WIDTH-1:0]        d_x,
    input  wire logic signed [COORD_WIDTH-1:0]        d_y,
    output logic                                      done,
    output logic                                      hit,
    output spi_pkg::kind_t                            kind,
    output logic signed [COORD_WIDTH-1:0]             point_x,
    output logic signed [COORD_WIDTH-1:0]             point_y
);

    import spi_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int P    = PARAM_FRAC_BITS;
    localparam int DW   = W + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 1;
    localparam int RW   = SW + 1;
    localparam int CW   = (SW > TOL_W) ? SW : TOL_W;
    localparam int QW   = P + 2;
    localparam int QS   = P + 2;
    localparam int MW   = P + 4;
    localparam int PRW  = MW + DW;
    localparam int OW   = DW + 3;
    localparam int XW   = OW + 1;
    localparam int SH_UP = (P >= OVL_TOL_W) ? P - OVL_TOL_W : 0;
    localparam int SH_DN = (P >= OVL_TOL_W) ? 0 : OVL_TOL_W - P;
    localparam int TWW  = OVL_TOL_W + SH_UP;

    localparam logic signed [MW-1:0]  PONE      = MW'(1 << P);
    localparam logic [QW-1:0]         QSAT      = QW'(2 << P);
    localparam logic [PRW:0]          HALF_T    = (PRW+1)'(1) << (P - 1);
    localparam logic [PRW:0]          HALF_M    = (PRW+1)'(1) << P;
    localparam logic signed [XW-1:0]  COORD_MAX = XW'((64'(1) << (W - 1)) - 64'(1));
    localparam logic signed [XW-1:0]  COORD_MIN = -XW'(64'(1) << (W - 1));

    typedef struct packed {
        logic [RW-1:0] r;
        logic [SW-1:0] d;
        logic [QW-1:0] q;
    } div_t;

    typedef struct packed {
        logic signed [W-1:0]  ax;
        logic signed [W-1:0]  ay;
        logic signed [DW-1:0] rx;
        logic signed [DW-1:0] ry;
        logic                 gen_ok;
        logic                 col_ok;
        logic                 sat0;
        logic                 sat1;
        logic                 neg0;
        logic                 neg1;
    } side_t;

    function automatic div_t div_step(div_t s, int j);
        logic [RW-1:0] rs;
        logic [RW-1:0] dv;
        div_t          o;
        rs = (j >= 2) ? (s.r << 1) : s.r;
        dv = (j == 0) ? {s.d, 1'b0} : RW'(s.d);
        o = s;
        if (rs >= dv)
        begin
            o.r = rs - dv;
            o.q = {s.q[QW-2:0], 1'b1};
        end
        else
        begin
            o.r = rs;
            o.q = {s.q[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    // configuration registers
    logic [TOL_W-1:0]     par_tol_reg;
    logic [TOL_W-1:0]     col_tol_reg;
    logic [OVL_TOL_W-1:0] ovl_tol_reg;
    reg_idx_t             cfg_idx;

    assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_tol_reg <= '0;
            col_tol_reg <= '0;
            ovl_tol_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (cfg_idx)
                REG_PAR_TOL: par_tol_reg <= pwdata[TOL_W-1:0];
                REG_COL_TOL: col_tol_reg <= pwdata[TOL_W-1:0];
                REG_OVL_TOL: ovl_tol_reg <= pwdata[OVL_TOL_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PAR_TOL: prdata = CFG_DATA_W'(par_tol_reg);
            REG_COL_TOL: prdata = CFG_DATA_W'(col_tol_reg);
            REG_OVL_TOL: prdata = CFG_DATA_W'(ovl_tol_reg);
            default:     prdata = '0;
        endcase
    end

    // valid bits
    logic          v1_reg, v2_reg, v3_reg;
    logic [QS:0]   vd_reg;
    logic          v5_reg, v6_reg, v7_reg;
    logic          done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vd_reg   <= '0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vd_reg   <= {vd_reg[QS-1:0], v3_reg};
            v5_reg   <= vd_reg[QS];
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            done_reg <= v7_reg;
        end
    end

    // stage 1: differences
    logic signed [W-1:0]  ax1_reg, ay1_reg;
    logic signed [DW-1:0] rx1_reg, ry1_reg, sx1_reg, sy1_reg;
    logic signed [DW-1:0] qx1_reg, qy1_reg, ex1_reg, ey1_reg;

    always_ff @(posedge clk)
    begin
        ax1_reg <= a_x;
        ay1_reg <= a_y;
        rx1_reg <= DW'(b_x) - DW'(a_x);
        ry1_reg <= DW'(b_y) - DW'(a_y);
        sx1_reg <= DW'(d_x) - DW'(c_x);
        sy1_reg <= DW'(d_y) - DW'(c_y);
        qx1_reg <= DW'(c_x) - DW'(a_x);
        qy1_reg <= DW'(c_y) - DW'(a_y);
        ex1_reg <= DW'(d_x) - DW'(a_x);
        ey1_reg <= DW'(d_y) - DW'(a_y);
    end

    // stage 2: products
    logic signed [W-1:0]  ax2_reg, ay2_reg;
    logic signed [DW-1:0] rx2_reg, ry2_reg;
    logic signed [PW-1:0] rxsy_reg, rysx_reg, qxsy_reg, qysx_reg, qxry_reg, qyrx_reg;
    logic signed [PW-1:0] rxrx_reg, ryry_reg, sxsx_reg, sysy_reg;
    logic signed [PW-1:0] qxrx_reg, qyry_reg, exrx_reg, eyry_reg;

    always_ff @(posedge clk)
    begin
        ax2_reg  <= ax1_reg;
        ay2_reg  <= ay1_reg;
        rx2_reg  <= rx1_reg;
        ry2_reg  <= ry1_reg;
        rxsy_reg <= rx1_reg * sy1_reg;
        rysx_reg <= ry1_reg * sx1_reg;
        qxsy_reg <= qx1_reg * sy1_reg;
        qysx_reg <= qy1_reg * sx1_reg;
        qxry_reg <= qx1_reg * ry1_reg;
        qyrx_reg <= qy1_reg * rx1_reg;
        rxrx_reg <= rx1_reg * rx1_reg;
        ryry_reg <= ry1_reg * ry1_reg;
        sxsx_reg <= sx1_reg * sx1_reg;
        sysy_reg <= sy1_reg * sy1_reg;
        qxrx_reg <= qx1_reg * rx1_reg;
        qyry_reg <= qy1_reg * ry1_reg;
        exrx_reg <= ex1_reg * rx1_reg;
        eyry_reg <= ey1_reg * ry1_reg;
    end

    // stage 3: cross and dot sums
    logic signed [W-1:0]  ax3_reg, ay3_reg;
    logic signed [DW-1:0] rx3_reg, ry3_reg;
    logic signed [SW-1:0] den3_reg, nt3_reg, nu3_reg, rr3_reg, ss3_reg, dot0_reg, dot1_reg;

    always_ff @(posedge clk)
    begin
        ax3_reg  <= ax2_reg;
        ay3_reg  <= ay2_reg;
        rx3_reg  <= rx2_reg;
        ry3_reg  <= ry2_reg;
        den3_reg <= SW'(rxsy_reg) - SW'(rysx_reg);
        nt3_reg  <= SW'(qxsy_reg) - SW'(qysx_reg);
        nu3_reg  <= SW'(qxry_reg) - SW'(qyrx_reg);
        rr3_reg  <= SW'(rxrx_reg) + SW'(ryry_reg);
        ss3_reg  <= SW'(sxsx_reg) + SW'(sysy_reg);
        dot0_reg <= SW'(qxrx_reg) + SW'(qyry_reg);
        dot1_reg <= SW'(exrx_reg) + SW'(eyry_reg);
    end

    // stage 4: classify and load the quotient lanes
    logic [SW-1:0]        den_abs, nu_abs, m0_abs, m1_abs, rr_u;
    logic signed [SW-1:0] nt_fix, nu_fix;
    logic                 par, sat0, sat1;
    div_t                 div0_next, div1_next;
    side_t                side_next;

    always_comb
    begin
        den_abs = den3_reg[SW-1] ? SW'(-den3_reg) : SW'(den3_reg);
        nu_abs  = nu3_reg[SW-1] ? SW'(-nu3_reg) : SW'(nu3_reg);
        m0_abs  = dot0_reg[SW-1] ? SW'(-dot0_reg) : SW'(dot0_reg);
        m1_abs  = dot1_reg[SW-1] ? SW'(-dot1_reg) : SW'(dot1_reg);
        rr_u    = SW'(rr3_reg);
        nt_fix  = den3_reg[SW-1] ? -nt3_reg : nt3_reg;
        nu_fix  = den3_reg[SW-1] ? -nu3_reg : nu3_reg;
        par     = (den3_reg == '0) || (CW'(den_abs) < CW'(par_tol_reg));
        sat0    = RW'(m0_abs) >= {rr_u, 1'b0};
        sat1    = RW'(m1_abs) >= {rr_u, 1'b0};

        side_next.ax     = ax3_reg;
        side_next.ay     = ay3_reg;
        side_next.rx     = rx3_reg;
        side_next.ry     = ry3_reg;
        side_next.gen_ok = !par && !nt_fix[SW-1] && (SW'(nt_fix) <= den_abs)
                           && !nu_fix[SW-1] && (SW'(nu_fix) <= den_abs);
        side_next.col_ok = par && (CW'(nu_abs) <= CW'(col_tol_reg))
                           && (rr3_reg != '0) && (ss3_reg != '0);
        // lane 0 carries t on the crossing path, so saturation applies only when parallel
        side_next.sat0   = par && sat0;
        side_next.sat1   = sat1;
        side_next.neg0   = dot0_reg[SW-1];
        side_next.neg1   = dot1_reg[SW-1];

        div0_next.r = par ? (sat0 ? '0 : RW'(m0_abs)) : RW'(SW'(nt_fix));
        div0_next.d = par ? rr_u : den_abs;
        div0_next.q = '0;
        div1_next.r = sat1 ? '0 : RW'(m1_abs);
        div1_next.d = rr_u;
        div1_next.q = '0;
    end

    // quotient lanes, one bit per stage
    div_t  da_reg [0:QS];
    div_t  db_reg [0:QS];
    side_t sd_reg [0:QS];

    always_ff @(posedge clk)
    begin
        da_reg[0] <= div0_next;
        db_reg[0] <= div1_next;
        sd_reg[0] <= side_next;
    end

    for (genvar j = 0; j < QS; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            da_reg[j+1] <= div_step(da_reg[j], j);
            db_reg[j+1] <= div_step(db_reg[j], j);
            sd_reg[j+1] <= sd_reg[j];
        end
    end

    // stage 5: clip overlap and pick the point parameter
    side_t                sq;
    logic [QW-1:0]        q0, q1;
    logic signed [MW-1:0] t0, t1, mn, mx, lo, hi, tol_s, mul5_next;
    logic [TWW-1:0]       tol_w;
    kind_t                kind5_next;

    always_comb
    begin
        sq    = sd_reg[QS];
        q0    = sq.sat0 ? QSAT : da_reg[QS].q;
        q1    = sq.sat1 ? QSAT : db_reg[QS].q;
        t0    = sq.neg0 ? -$signed(MW'(q0)) : $signed(MW'(q0));
        t1    = sq.neg1 ? -$signed(MW'(q1)) : $signed(MW'(q1));
        mn    = (t0 < t1) ? t0 : t1;
        mx    = (t0 < t1) ? t1 : t0;
        lo    = (mn > 0) ? mn : '0;
        hi    = (mx < PONE) ? mx : PONE;
        tol_w = (TWW'(ovl_tol_reg) << SH_UP) >> SH_DN;
        tol_s = $signed(MW'(tol_w[P-1:0]));
        if (sq.gen_ok)
        begin
            kind5_next = KIND_CROSS;
            mul5_next  = $signed(MW'(q0));
        end
        else if (sq.col_ok && !(lo > hi + tol_s))
        begin
            kind5_next = KIND_OVERLAP;
            mul5_next  = lo + hi;
        end
        else
        begin
            kind5_next = KIND_NONE;
            mul5_next  = lo + hi;
        end
    end

    kind_t                kind5_reg;
    logic signed [MW-1:0] mul5_reg;
    logic signed [W-1:0]  ax5_reg, ay5_reg;
    logic signed [DW-1:0] rx5_reg, ry5_reg;

    always_ff @(posedge clk)
    begin
        kind5_reg <= kind5_next;
        mul5_reg  <= mul5_next;
        ax5_reg   <= sq.ax;
        ay5_reg   <= sq.ay;
        rx5_reg   <= sq.rx;
        ry5_reg   <= sq.ry;
    end

    // stage 6: offset products
    kind_t                 kind6_reg;
    logic signed [W-1:0]   ax6_reg, ay6_reg;
    logic signed [PRW-1:0] px6_reg, py6_reg;

    always_ff @(posedge clk)
    begin
        kind6_reg <= kind5_reg;
        ax6_reg   <= ax5_reg;
        ay6_reg   <= ay5_reg;
        px6_reg   <= mul5_reg * rx5_reg;
        py6_reg   <= mul5_reg * ry5_reg;
    end

    // stage 7: round to nearest, ties away from zero
    logic [PRW-1:0]       magx, magy;
    logic [PRW:0]         sumx, sumy, half, shx, shy;
    logic signed [OW-1:0] offx_next, offy_next;

    always_comb
    begin
        magx = px6_reg[PRW-1] ? PRW'(-px6_reg) : PRW'(px6_reg);
        magy = py6_reg[PRW-1] ? PRW'(-py6_reg) : PRW'(py6_reg);
        half = (kind6_reg == KIND_CROSS) ? HALF_T : HALF_M;
        sumx = {1'b0, magx} + half;
        sumy = {1'b0, magy} + half;
        shx  = (kind6_reg == KIND_CROSS) ? (sumx >> P) : (sumx >> (P + 1));
        shy  = (kind6_reg == KIND_CROSS) ? (sumy >> P) : (sumy >> (P + 1));
        offx_next = px6_reg[PRW-1] ? -$signed(OW'(shx)) : $signed(OW'(shx));
        offy_next = py6_reg[PRW-1] ? -$signed(OW'(shy)) : $signed(OW'(shy));
    end

    kind_t                kind7_reg;
    logic signed [W-1:0]  ax7_reg, ay7_reg;
    logic signed [OW-1:0] offx7_reg, offy7_reg;

    always_ff @(posedge clk)
    begin
        kind7_reg <= kind6_reg;
        ax7_reg   <= ax6_reg;
        ay7_reg   <= ay6_reg;
        offx7_reg <= offx_next;
        offy7_reg <= offy_next;
    end

    // output stage: add base point and saturate
    logic signed [XW-1:0] sx_sum, sy_sum;
    logic signed [W-1:0]  satx, saty;
    logic                 hit_next;

    always_comb
    begin
        sx_sum   = XW'(ax7_reg) + XW'(offx7_reg);
        sy_sum   = XW'(ay7_reg) + XW'(offy7_reg);
        satx     = (sx_sum > COORD_MAX) ? W'(COORD_MAX) :
                   (sx_sum < COORD_MIN) ? W'(COORD_MIN) : W'(sx_sum);
        saty     = (sy_sum > COORD_MAX) ? W'(COORD_MAX) :
                   (sy_sum < COORD_MIN) ? W'(COORD_MIN) : W'(sy_sum);
        hit_next = kind7_reg != KIND_NONE;
    end

    logic                hit_reg;
    kind_t               kind_reg;
    logic signed [W-1:0] point_x_reg, point_y_reg;

    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        kind_reg    <= kind7_reg;
        point_x_reg <= hit_next ? satx : '0;
        point_y_reg <= hit_next ? saty : '0;
    end

    assign done    = done_reg;
    assign hit     = hit_reg;
    assign kind    = kind_reg;
    assign point_x = point_x_reg;
    assign point_y = point_y_reg;

endmodule

`default_nettype wire

/* rtl/core/spi_checker.sv */
// port-level checks for the segment pair intersection core, bound to the top level
// depends on spi_pkg and segment_pair_intersection_core_macros.svh
`default_nettype none

`include "segment_pair_intersection_core_macros.svh"

module spi_checker #(
    parameter int COORD_WIDTH     = 24,
    parameter int PARAM_FRAC_BITS = 16
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic                          hit,
    input wire spi_pkg::kind_t                kind,
    input wire logic signed [COORD_WIDTH-1:0] point_x,
    input wire logic signed [COORD_WIDTH-1:0] point_y
);

    import spi_pkg::*;

    localparam int LATENCY = PARAM_FRAC_BITS + 10;

    `SPI_ASSERT_NOW(a_miss_zero, done && !hit, point_x == '0 && point_y == '0)
    `SPI_ASSERT_NOW(a_hit_kind, done, hit == (kind != KIND_NONE))
    `SPI_ASSERT_NEXT(a_word_out, start && !busy, ##(LATENCY - 1) done)
    `SPI_ASSERT_NEXT(a_no_extra, !(start && !busy), ##(LATENCY - 1) !done)

endmodule

bind segment_pair_intersection_core spi_checker #(
    .COORD_WIDTH     (COORD_WIDTH),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
) u_spi_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .hit     (hit),
    .kind    (kind),
    .point_x (point_x),
    .point_y (point_y)
);

`default_nettype wire
